// ===== src/ftr_pkg.sv =====
// ftr_pkg: shared types and constants for the first-touch renumbering block
// no dependencies; imported by every module of the block
`default_nettype none

package ftr_pkg;

	// data index space and taken store geometry
	localparam int MAX_DATA = 1024;
	localparam int IDX_W    = 10;
	localparam int CNT_W    = IDX_W + 1;
	localparam int WORD_W   = 32;
	localparam int BIT_AW   = 5;
	localparam int ROWS     = MAX_DATA / WORD_W;
	localparam int ROW_AW   = IDX_W - BIT_AW;

	// operation codes
	localparam logic [1:0] OP_TOUCH   = 2'd0;
	localparam logic [1:0] OP_DRAIN   = 2'd1;
	localparam logic [1:0] OP_RESTART = 2'd2;
	localparam logic [1:0] OP_UNUSED  = 2'd3;

	typedef logic [WORD_W-1:0] row_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TOUCH,
		ST_DRAIN
	} ftr_state_t;

	// taken store access request
	typedef struct packed {
		logic              we;
		logic [ROW_AW-1:0] waddr;
		row_t              wdata;
		logic              re;
		logic [ROW_AW-1:0] raddr;
	} ram_req_t;

endpackage

`default_nettype wire

// ===== src/first_touch_renumbering.sv =====
// first_touch_renumbering: top level of the first-touch data renumbering block
// holds the num_data register; instantiates ftr_ctrl and ftr_taken_ram; uses ftr_pkg
//
// Builds a data reordering permutation. A transaction is taken when start is high and
// busy is low. Touch (operation 0) maps a first-touched data_index below num_data to the
// next new number; repeat or out-of-range touches give no result. Drain (operation 1)
// hands out the lowest untouched index with the next new number, or all_done once none
// is left. Restart (operation 2) clears the taken store and counters; operation 3 does
// nothing. Each result shows for exactly one cycle with strobe high and cannot be held
// off by the receiver. A touch reads its row of the taken store and, on a first touch,
// writes it back; a drain scans the taken store one 32-index row at a time; a restart,
// and reset, run a clearing pass over all 32 rows (one row per cycle) with busy high.
// The row store has a single read and a single write port. num_data may be written at
// any idle time, takes effect at once, and values above 1024 act as 1024.
`default_nettype none

module first_touch_renumbering (
	input  logic                      clk,
	input  logic                      arst_n,
	// transaction in
	input  logic                      start,
	output logic                      busy,
	input  logic [1:0]                operation,
	input  logic [ftr_pkg::IDX_W-1:0] data_index,
	// configuration
	input  logic                      num_data_we,
	input  logic [ftr_pkg::CNT_W-1:0] num_data,
	// results
	output logic                      strobe,
	output logic [ftr_pkg::IDX_W-1:0] old_index,
	output logic [ftr_pkg::IDX_W-1:0] new_index,
	output logic                      all_done
);
	import ftr_pkg::*;

	logic [CNT_W-1:0] num_data_q;
	logic [CNT_W-1:0] active_n;
	ram_req_t         ram_req;
	row_t             rd_row;

	// register write is not guarded; the user must write it only while idle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_data_q <= CNT_W'(MAX_DATA);
		end else if (num_data_we) begin
			num_data_q <= num_data;
		end
	end

	// effective count saturates at the store size
	assign active_n = (num_data_q > CNT_W'(MAX_DATA)) ? CNT_W'(MAX_DATA) : num_data_q;

	ftr_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.operation  (operation),
		.data_index (data_index),
		.active_n   (active_n),
		.rd_row     (rd_row),
		.ram_req    (ram_req),
		.busy       (busy),
		.strobe     (strobe),
		.old_index  (old_index),
		.new_index  (new_index),
		.all_done   (all_done)
	);

	// one taken bit per data index, 32 per row
	ftr_taken_ram u_taken_ram (
		.clk    (clk),
		.req    (ram_req),
		.rd_row (rd_row)
	);

endmodule

`default_nettype wire

// ===== src/ftr_taken_ram.sv =====
// ftr_taken_ram: taken bit store, one row of taken bits per entry
// one write port, one read port with registered read data; uses ftr_pkg
`default_nettype none

module ftr_taken_ram (
	input  logic              clk,
	input  ftr_pkg::ram_req_t req,
	output ftr_pkg::row_t     rd_row
);
	import ftr_pkg::*;

	row_t mem [ROWS];

	always_ff @(posedge clk) begin
		if (req.we) begin
			mem[req.waddr] <= req.wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (req.re) begin
			rd_row <= mem[req.raddr];
		end
	end

endmodule

`default_nettype wire

// ===== src/ftr_ctrl.sv =====
// ftr_ctrl: sequencer for touch, drain and restart transactions
// read-modify-write of taken rows, row scan for drains, clearing pass; uses ftr_pkg
`default_nettype none

module ftr_ctrl (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [1:0]                  operation,
	input  logic [ftr_pkg::IDX_W-1:0]   data_index,
	input  logic [ftr_pkg::CNT_W-1:0]   active_n,
	input  ftr_pkg::row_t               rd_row,
	output ftr_pkg::ram_req_t           ram_req,
	output logic                        busy,
	output logic                        strobe,
	output logic [ftr_pkg::IDX_W-1:0]   old_index,
	output logic [ftr_pkg::IDX_W-1:0]   new_index,
	output logic                        all_done
);
	import ftr_pkg::*;

	ftr_state_t         state_q, state_d;
	logic [ROW_AW-1:0]  clr_cnt_q, clr_cnt_d;
	logic [IDX_W-1:0]   idx_q, idx_d;
	logic [CNT_W-1:0]   next_num_q, next_num_d;
	logic [CNT_W-1:0]   scan_q, scan_d;
	logic               strobe_q, strobe_d;
	logic [IDX_W-1:0]   old_q, old_d;
	logic [IDX_W-1:0]   new_q, new_d;
	logic               done_q, done_d;

	// drain scan of the current row
	row_t               masked_row;
	logic [BIT_AW-1:0]  first_zero;
	logic               zero_found;
	logic [IDX_W-1:0]   drain_pos;
	logic               drain_hit;
	logic [ROW_AW:0]    row_inc;
	logic [CNT_W-1:0]   next_base;
	logic               scan_end;

	logic               touch_ok;
	logic               drain_start;
	logic               clr_last;

	assign touch_ok    = {1'b0, data_index} < active_n;
	assign drain_start = scan_q < active_n;
	assign clr_last    = clr_cnt_q == ROW_AW'(ROWS - 1);

	always_comb begin
		masked_row = rd_row | ((row_t'(1) << scan_q[BIT_AW-1:0]) - row_t'(1));
		first_zero = '0;
		zero_found = 1'b0;
		for (int i = WORD_W - 1; i >= 0; i--) begin
			if (!masked_row[i]) begin
				first_zero = BIT_AW'(i);
				zero_found = 1'b1;
			end
		end
		drain_pos = {scan_q[IDX_W-1:BIT_AW], first_zero};
		drain_hit = zero_found && ({1'b0, drain_pos} < active_n);
		row_inc   = {1'b0, scan_q[IDX_W-1:BIT_AW]} + (ROW_AW + 1)'(1);
		next_base = {row_inc, {BIT_AW{1'b0}}};
		scan_end  = next_base >= active_n;
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				if (clr_last) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (start) begin
					if (operation == OP_TOUCH && touch_ok) begin
						state_d = ST_TOUCH;
					end else if (operation == OP_DRAIN && drain_start) begin
						state_d = ST_DRAIN;
					end else if (operation == OP_RESTART) begin
						state_d = ST_CLEAR;
					end
				end
			end
			ST_TOUCH: state_d = ST_IDLE;
			ST_DRAIN: begin
				if (drain_hit || scan_end) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// datapath and outputs
	always_comb begin
		ram_req    = '0;
		clr_cnt_d  = clr_cnt_q;
		idx_d      = idx_q;
		next_num_d = next_num_q;
		scan_d     = scan_q;
		strobe_d   = 1'b0;
		old_d      = '0;
		new_d      = '0;
		done_d     = 1'b0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_req.we    = 1'b1;
				ram_req.waddr = clr_cnt_q;
				ram_req.wdata = '0;
				clr_cnt_d     = clr_cnt_q + ROW_AW'(1);
			end
			ST_IDLE: begin
				if (start) begin
					unique case (operation)
						OP_TOUCH: begin
							idx_d         = data_index;
							ram_req.re    = touch_ok;
							ram_req.raddr = data_index[IDX_W-1:BIT_AW];
						end
						OP_DRAIN: begin
							if (drain_start) begin
								ram_req.re    = 1'b1;
								ram_req.raddr = scan_q[IDX_W-1:BIT_AW];
							end else begin
								strobe_d = 1'b1;
								done_d   = 1'b1;
							end
						end
						OP_RESTART: begin
							next_num_d = '0;
							scan_d     = '0;
							clr_cnt_d  = '0;
						end
						default: ;
					endcase
				end
			end
			ST_TOUCH: begin
				if (!rd_row[idx_q[BIT_AW-1:0]]) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = idx_q[IDX_W-1:BIT_AW];
					ram_req.wdata = rd_row | (row_t'(1) << idx_q[BIT_AW-1:0]);
					strobe_d      = 1'b1;
					old_d         = idx_q;
					new_d         = next_num_q[IDX_W-1:0];
					next_num_d    = next_num_q + CNT_W'(1);
				end
			end
			ST_DRAIN: begin
				if (drain_hit) begin
					ram_req.we    = 1'b1;
					ram_req.waddr = drain_pos[IDX_W-1:BIT_AW];
					ram_req.wdata = rd_row | (row_t'(1) << first_zero);
					strobe_d      = 1'b1;
					old_d         = drain_pos;
					new_d         = next_num_q[IDX_W-1:0];
					next_num_d    = next_num_q + CNT_W'(1);
					scan_d        = {1'b0, drain_pos} + CNT_W'(1);
				end else if (scan_end) begin
					strobe_d = 1'b1;
					done_d   = 1'b1;
					scan_d   = active_n;
				end else begin
					scan_d        = next_base;
					ram_req.re    = 1'b1;
					ram_req.raddr = next_base[IDX_W-1:BIT_AW];
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_cnt_q  <= '0;
			next_num_q <= '0;
			scan_q     <= '0;
			strobe_q   <= 1'b0;
		end else begin
			state_q    <= state_d;
			clr_cnt_q  <= clr_cnt_d;
			next_num_q <= next_num_d;
			scan_q     <= scan_d;
			strobe_q   <= strobe_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q  <= idx_d;
		old_q  <= old_d;
		new_q  <= new_d;
		done_q <= done_d;
	end

	assign busy      = state_q != ST_IDLE;
	assign strobe    = strobe_q;
	assign old_index = old_q;
	assign new_index = new_q;
	assign all_done  = done_q;

endmodule

`default_nettype wire

// ===== src/ftr_checker.sv =====
// ftr_checker: port-level assertions for first_touch_renumbering
// bound to the top level below; uses ftr_pkg
`default_nettype none

module ftr_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      start,
	input logic                      busy,
	input logic [1:0]                operation,
	input logic                      strobe,
	input logic [ftr_pkg::IDX_W-1:0] old_index,
	input logic [ftr_pkg::IDX_W-1:0] new_index,
	input logic                      all_done
);
	import ftr_pkg::*;

	// restart gives no result and starts the clearing pass
	a_restart_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_RESTART) |=> (!strobe && busy))
		else $error("restart produced a result or did not clear");

	// unused operation code has no effect on results
	a_op3_quiet: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_UNUSED) |=> !strobe)
		else $error("operation three produced a result");

	// done report carries zero indices
	a_done_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && all_done) |-> (old_index == '0 && new_index == '0))
		else $error("done result with nonzero indices");

	// a result follows only an accepted transaction or work in progress
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		(!$past(busy) && !$past(start)) |-> !strobe)
		else $error("result without a transaction");

endmodule

bind first_touch_renumbering ftr_checker u_ftr_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.start     (start),
	.busy      (busy),
	.operation (operation),
	.strobe    (strobe),
	.old_index (old_index),
	.new_index (new_index),
	.all_done  (all_done)
);

`default_nettype wire
